// File: hw/rtl/hps_pkg.sv
// Shared types and constants for the HDR pixel three-scale split.
`timescale 1ns / 1ps
package hps_pkg;

    localparam int CH_W       = 24;   // Q8.16 channel
    localparam int PROD_W     = 48;   // channel times gain
    localparam int E_W        = 33;   // doubled reconstruction error
    localparam int P_W        = 40;   // weighted level error
    localparam int T_W        = 42;   // total error over three levels
    localparam int R_W        = T_W + 1;
    localparam int QUO_W      = 17;   // quotient reaches 65536
    localparam int DIV_STAGES = QUO_W;
    localparam int LEVELS_OUT = 3;
    localparam int BASE_SHIFT = 14;
    localparam int LVL_STEP   = 3;

    localparam logic [CH_W-1:0] CH_MAX    = 24'hFFFFFF;
    localparam logic [15:0]     ALPHA_ONE = 16'hFFFF;
    localparam logic [6:0]      W_RED     = 7'd30;
    localparam logic [6:0]      W_GREEN   = 7'd59;
    localparam logic [6:0]      W_BLUE    = 7'd11;

    typedef struct packed {
        logic [23:0] red_in;
        logic [23:0] green_in;
        logic [23:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]  lvl0_red;
        logic [7:0]  lvl0_green;
        logic [7:0]  lvl0_blue;
        logic [15:0] lvl0_alpha;
        logic [7:0]  lvl1_red;
        logic [7:0]  lvl1_green;
        logic [7:0]  lvl1_blue;
        logic [15:0] lvl1_alpha;
        logic [7:0]  lvl2_red;
        logic [7:0]  lvl2_green;
        logic [7:0]  lvl2_blue;
        logic [15:0] lvl2_alpha;
    } pix_out_t;

endpackage

// File: hw/rtl/hps_lane.sv
// One scale level: quantize three channels, measure and weight the error.
`timescale 1ns / 1ps
module hps_lane import hps_pkg::*; #(
    parameter int LEVEL = 0
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [2:0][CH_W-1:0]      s_in,
    output logic [2:0][7:0]           q_out,
    output logic [P_W-1:0]            p_out
);
    localparam int SH = BASE_SHIFT + LVL_STEP * LEVEL;
    localparam logic [CH_W:0] QSCALE = (CH_W+1)'(1) << SH;

    logic [2:0][7:0]     q_next, q_reg, q2_reg;
    logic [2:0][E_W-1:0] e_next, e_reg;
    logic [P_W-1:0]      p_next, p_reg;

    always_comb begin
        logic [31:0] a, b, qf, d;
        for (int c = 0; c < 3; c++) begin
            a  = {s_in[c], 8'b0} - {8'b0, s_in[c]};
            qf = a >> SH;
            q_next[c] = (qf > 32'd255) ? 8'hFF : qf[7:0];
            b  = {24'b0, q_next[c]} << SH;
            d  = (a >= b) ? a - b : b - a;
            e_next[c] = ({1'b0, s_in[c]} > QSCALE) ? {d, 1'b0} : {1'b0, d};
        end
        p_next = P_W'(e_reg[0]) * P_W'(W_RED) + P_W'(e_reg[1]) * P_W'(W_GREEN)
               + P_W'(e_reg[2]) * P_W'(W_BLUE);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg  <= q_next;
            e_reg  <= e_next;
            q2_reg <= q_reg;
            p_reg  <= p_next;
        end
    end

    assign q_out = q2_reg;
    assign p_out = p_reg;
endmodule

// File: hw/rtl/hps_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module hps_div import hps_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [T_W-1:0]   num_in,   // below twice den_in
    input  logic [T_W-1:0]   den_in,
    output logic [QUO_W-1:0] quo_out,
    output logic [T_W-1:0]   den_out
);
    logic [R_W-1:0]   rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];
    logic [T_W-1:0]   den_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stg
        logic [R_W-1:0]   r_in, r_sub;
        logic [T_W-1:0]   d_in;
        logic [QUO_W-1:0] q_in;
        logic             take;
        if (j == 0) begin : g_first
            assign r_in = {1'b0, num_in};
            assign d_in = den_in;
            assign q_in = '0;
        end else begin : g_next
            assign r_in = {rem_reg[j-1][R_W-2:0], 1'b0};
            assign d_in = den_reg[j-1];
            assign q_in = quo_reg[j-1];
        end
        assign take  = r_in >= {1'b0, d_in};
        assign r_sub = r_in - {1'b0, d_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= take ? r_sub : r_in;
                quo_reg[j] <= {q_in[QUO_W-2:0], take};
                den_reg[j] <= d_in;
            end
        end
    end

    assign quo_out = quo_reg[DIV_STAGES-1];
    assign den_out = den_reg[DIV_STAGES-1];
endmodule

// File: hw/rtl/hdr_pixel_three_scale_split.sv
// Top level: gain, three quantizer lanes, per-lane dividers, alpha merge.
//
//  port group      dir  handshake           word
//  s_*             in   s_valid / s_ready   pix_in_t  (RGB, Q8.16)
//  m_*             out  m_valid / m_ready   pix_out_t (3 levels x RGB byte + alpha)
//  cfg_*           in   cfg_we              24-bit gain, Q8.16
//
// One word enters per cycle unless m_ready stalls the pipe; the path runs gain multiply, quantize,
// weight, total, 17 divider stages, merge/output register.
// The whole pipe advances whenever the output register is empty or taken, so
// a stall at m_ready freezes every stage in place; s_ready follows it.
// Synchronous active-low reset clears valid bits and loads gain = 1.0.
`timescale 1ns / 1ps
module hdr_pixel_three_scale_split import hps_pkg::*; #(
    parameter int NUM_LEVELS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pix_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pix_out_t    m_data,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata
);
    localparam int PIPE = 4 + DIV_STAGES;   // stages before the output register

    logic en;
    logic [23:0] gain_reg;
    logic [PIPE-1:0] v_reg;
    logic m_valid_reg;
    pix_out_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= 24'h010000;
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_wdata;
            end
            if (en) begin
                v_reg       <= {v_reg[PIPE-2:0], s_valid};
                m_valid_reg <= v_reg[PIPE-1];
            end
        end
    end

    // stage 1: gain multiply per channel
    logic [2:0][PROD_W-1:0] prod_reg;
    logic [2:0][CH_W-1:0]   s_sat;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= s_data.red_in   * gain_reg;
            prod_reg[1] <= s_data.green_in * gain_reg;
            prod_reg[2] <= s_data.blue_in  * gain_reg;
        end
    end
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_sat[c] = (|prod_reg[c][PROD_W-1:40]) ? CH_MAX : prod_reg[c][39:16];
        end
    end

    // stages 2-3: lanes, one per scale level
    logic [2:0][7:0] lane_q [LEVELS_OUT];
    logic [P_W-1:0]  lane_p [LEVELS_OUT];
    for (genvar l = 0; l < LEVELS_OUT; l++) begin : g_lane
        if (l < NUM_LEVELS) begin : g_on
            hps_lane #(.LEVEL(l)) u_lane (
                .aclk (aclk), .en (en), .s_in (s_sat),
                .q_out(lane_q[l]), .p_out(lane_p[l])
            );
        end else begin : g_off
            assign lane_q[l] = '0;
            assign lane_p[l] = '0;
        end
    end

    // stage 4: total error
    logic [T_W-1:0]  t_reg;
    logic [P_W-1:0]  p4_reg [LEVELS_OUT];
    logic [2:0][7:0] q4_reg [LEVELS_OUT];
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= T_W'(lane_p[0]) + T_W'(lane_p[1]) + T_W'(lane_p[2]);
            for (int l = 0; l < LEVELS_OUT; l++) begin
                p4_reg[l] <= lane_p[l];
                q4_reg[l] <= lane_q[l];
            end
        end
    end

    // divider lanes; bytes ride a matching delay line
    logic [QUO_W-1:0] quo [LEVELS_OUT];
    logic [T_W-1:0]   den [LEVELS_OUT];
    for (genvar l = 0; l < LEVELS_OUT; l++) begin : g_div
        if (l < NUM_LEVELS) begin : g_on
            hps_div u_div (
                .aclk  (aclk), .en (en),
                .num_in(t_reg - T_W'(p4_reg[l])), .den_in(t_reg),
                .quo_out(quo[l]), .den_out(den[l])
            );
        end else begin : g_off
            assign quo[l] = '0;
            assign den[l] = '0;
        end
    end

    logic [2:0][7:0] qd_reg [DIV_STAGES][LEVELS_OUT];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LEVELS_OUT; l++) begin
                qd_reg[0][l] <= q4_reg[l];
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                for (int l = 0; l < LEVELS_OUT; l++) begin
                    qd_reg[k][l] <= qd_reg[k-1][l];
                end
            end
        end
    end

    // merge: saturate, zero-total rule, pack the word
    logic [15:0] alpha [LEVELS_OUT];
    always_comb begin
        for (int l = 0; l < LEVELS_OUT; l++) begin
            if (l >= NUM_LEVELS) begin
                alpha[l] = '0;
            end else if (den[l] == '0) begin
                // every used lane carries the same total
                alpha[l] = (l == 0) ? ALPHA_ONE : 16'd0;
            end else begin
                alpha[l] = quo[l][QUO_W-1] ? ALPHA_ONE : quo[l][15:0];
            end
        end
        m_data_next.lvl0_red   = qd_reg[DIV_STAGES-1][0][0];
        m_data_next.lvl0_green = qd_reg[DIV_STAGES-1][0][1];
        m_data_next.lvl0_blue  = qd_reg[DIV_STAGES-1][0][2];
        m_data_next.lvl0_alpha = alpha[0];
        m_data_next.lvl1_red   = qd_reg[DIV_STAGES-1][1][0];
        m_data_next.lvl1_green = qd_reg[DIV_STAGES-1][1][1];
        m_data_next.lvl1_blue  = qd_reg[DIV_STAGES-1][1][2];
        m_data_next.lvl1_alpha = alpha[1];
        m_data_next.lvl2_red   = qd_reg[DIV_STAGES-1][2][0];
        m_data_next.lvl2_green = qd_reg[DIV_STAGES-1][2][1];
        m_data_next.lvl2_blue  = qd_reg[DIV_STAGES-1][2][2];
        m_data_next.lvl2_alpha = alpha[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    // reset empties the pipe
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid && v_reg == '0)
        else $error("pipe not empty after reset");
    // a frozen pipe keeps its last stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg) && $stable(quo[0]))
        else $error("pipe moved during stall");
    // a single level gives only the extreme alphas
    a_one_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && NUM_LEVELS == 1 |->
            m_data.lvl0_alpha == 16'd0 || m_data.lvl0_alpha == ALPHA_ONE)
        else $error("single-level alpha out of range");
    // unused level stays zero
    a_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && NUM_LEVELS < 3 |-> m_data.lvl2_alpha == 16'd0 && m_data.lvl2_red == 8'd0)
        else $error("unused level not zero");
endmodule
